[design/dnle_pkg.sv]
// Package with the constants, state type and request struct of the DNS name label encoder.
`default_nettype none

package dnle_pkg;

  // Longest label that is kept; characters beyond this count are dropped.
  localparam int unsigned MAX_LABEL = 63;

  // Width of one name character and of one wire-format byte.
  localparam int unsigned BYTE_W = 8;

  // The label separator character.
  localparam logic [BYTE_W-1:0] SEPARATOR = 8'h2E;

  // States of the label replay sequencer.
  typedef enum logic [1:0] {
    EmIdle,
    EmLen,
    EmRead,
    EmChar
  } emit_state_e;

  // Request from the input side to replay one buffered label.
  typedef struct packed {
    logic              start;
    logic [BYTE_W-1:0] len;
    logic              ovf;
    logic              done;
  } emit_req_t;

endpackage

`default_nettype wire

[design/dnle_label_ram.sv]
// Label character buffer: one write port and one registered read port.
`default_nettype none

module dnle_label_ram #(
  parameter int unsigned Depth = dnle_pkg::MAX_LABEL,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        wr_en_i,
  input  wire logic [AddrW-1:0]            wr_addr_i,
  input  wire logic [dnle_pkg::BYTE_W-1:0] wr_data_i,
  input  wire logic                        rd_en_i,
  input  wire logic [AddrW-1:0]            rd_addr_i,
  output logic      [dnle_pkg::BYTE_W-1:0] rd_data_o
);
  import dnle_pkg::*;

  logic [BYTE_W-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // The read data holds until the next read, so a stalled consumer can wait on it.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

[design/dnle_emit.sv]
// Label replay sequencer: sends the length byte, then reads the buffer and sends each character.
`default_nettype none

module dnle_emit #(
  parameter int unsigned MaxLabel = dnle_pkg::MAX_LABEL,
  parameter int unsigned AddrW    = (MaxLabel > 1) ? $clog2(MaxLabel) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire dnle_pkg::emit_req_t         req_i,
  output logic                             busy_o,
  output logic                             rd_en_o,
  output logic      [AddrW-1:0]            rd_addr_o,
  input  wire logic [dnle_pkg::BYTE_W-1:0] rd_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [dnle_pkg::BYTE_W-1:0] byte_out_o,
  output logic                             is_length_o,
  output logic                             run_last_o,
  output logic                             name_done_o,
  output logic                             label_overflow_o
);
  import dnle_pkg::*;

  emit_state_e       state_q, state_d;
  logic [AddrW-1:0]  idx_q, idx_d;
  logic [BYTE_W-1:0] len_q;
  logic              lovf_q;
  logic              done_q;

  logic              out_free;
  logic              last_chr;
  logic              capture;
  logic              load_len;
  logic              load_chr;

  assign out_free = !out_valid_o || !out_stall_i;
  assign last_chr = (BYTE_W'(idx_q) == (len_q - BYTE_W'(1)));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      EmIdle: begin
        if (req_i.start) begin
          state_d = EmLen;
        end
      end
      EmLen: begin
        if (out_free) begin
          state_d = (len_q == '0) ? EmIdle : EmRead;
        end
      end
      EmRead: begin
        state_d = EmChar;
      end
      EmChar: begin
        if (out_free) begin
          state_d = last_chr ? EmIdle : EmRead;
        end
      end
      default: begin
        state_d = EmIdle;
      end
    endcase
  end

  always_comb begin
    capture  = 1'b0;
    load_len = 1'b0;
    load_chr = 1'b0;
    rd_en_o  = 1'b0;
    unique case (state_q)
      EmIdle: begin
        capture = req_i.start;
      end
      EmLen: begin
        load_len = out_free;
      end
      EmRead: begin
        rd_en_o = 1'b1;
      end
      EmChar: begin
        load_chr = out_free;
      end
      default: begin
        capture = 1'b0;
      end
    endcase
  end

  assign busy_o    = (state_q != EmIdle);
  assign rd_addr_o = idx_q;

  always_comb begin
    idx_d = idx_q;
    if (capture) begin
      idx_d = '0;
    end else if (load_chr && !last_chr) begin
      idx_d = idx_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EmIdle;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      len_q  <= req_i.len;
      lovf_q <= req_i.ovf;
      done_q <= req_i.done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (load_len || load_chr) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_len) begin
      byte_out_o       <= len_q;
      is_length_o      <= 1'b1;
      run_last_o       <= (len_q == '0);
      name_done_o      <= (len_q == '0) && done_q;
      label_overflow_o <= lovf_q;
    end else if (load_chr) begin
      byte_out_o       <= rd_data_i;
      is_length_o      <= 1'b0;
      run_last_o       <= last_chr;
      name_done_o      <= last_chr && done_q;
      label_overflow_o <= 1'b0;
    end
  end

  // The end of a name always closes the run of the word that carries it.
  a_done_is_run_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && name_done_o |-> run_last_o)
    else $error("name_done without run_last");

  // The overflow flag only ever rides on a length byte.
  a_ovf_on_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && label_overflow_o |-> is_length_o)
    else $error("label_overflow on a character byte");

  // Character reads never run past the captured label length.
  a_idx_in_label: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == EmChar) || (state_q == EmRead) |-> BYTE_W'(idx_q) < len_q)
    else $error("buffer read beyond label length");

endmodule

`default_nettype wire

[design/dns_name_label_encoder_core.sv]
// Top level of the DNS name label encoder: input side, label buffer and replay sequencer.
//
// The block turns a dotted name, one character per input word, into DNS wire
// format. The input channel (in_valid_i, in_stall_o) carries char_in_i and
// last_char_i; the output channel (out_valid_o, out_stall_i) carries one
// wire-format byte per word with its flags. A word moves at a rising edge
// where valid is high and stall is low.
// An ordinary character is written into the label buffer in the cycle it is
// accepted and causes no output; the next character can follow in the next
// cycle. A separator, or a final character, starts the replay of the label:
// the sequencer first loads the length byte into the output register, then,
// for each buffered character, reads it from the buffer and loads it into
// the output register. The input is stalled during the replay; the input
// opens again once the last byte is loaded. Characters past MaxLabel are
// dropped and flagged on the length byte. A stalled receiver holds the
// output register and freezes the replay. Reset clears the label count, the
// overflow flag, the sequencer and the output valid; the buffer contents
// need no clearing.
`default_nettype none

module dns_name_label_encoder_core #(
  parameter int unsigned MaxLabel = dnle_pkg::MAX_LABEL
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [dnle_pkg::BYTE_W-1:0] char_in_i,
  input  wire logic                        last_char_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [dnle_pkg::BYTE_W-1:0] byte_out_o,
  output logic                             is_length_o,
  output logic                             run_last_o,
  output logic                             name_done_o,
  output logic                             label_overflow_o
);
  import dnle_pkg::*;

  localparam int unsigned AddrW = (MaxLabel > 1) ? $clog2(MaxLabel) : 1;
  localparam int unsigned CntW  = $clog2(MaxLabel + 1);

  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              ovf_q, ovf_d;

  logic              accept;
  logic              is_sep;
  logic              room;
  logic              store;
  logic              emit;
  logic [CntW-1:0]   cnt_buf;
  logic              ovf_buf;
  logic              busy;
  logic              rd_en;
  logic [AddrW-1:0]  rd_addr;
  logic [BYTE_W-1:0] rd_data;
  emit_req_t         req;

  // Input words are taken only while no label is being replayed.
  assign in_stall_o = busy;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_sep = (char_in_i == SEPARATOR);
  assign room   = (cnt_q < CntW'(MaxLabel));
  assign store  = !is_sep && room;
  assign emit   = is_sep || last_char_i;

  // Count and overflow as they stand once this character is buffered or dropped.
  assign cnt_buf = store ? (cnt_q + CntW'(1)) : cnt_q;
  assign ovf_buf = ovf_q || (!is_sep && !room);

  always_comb begin
    req.start = accept && emit;
    req.len   = BYTE_W'(cnt_buf);
    req.ovf   = ovf_buf;
    req.done  = last_char_i;
  end

  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (accept) begin
      if (emit) begin
        cnt_d = '0;
        ovf_d = 1'b0;
      end else begin
        cnt_d = cnt_buf;
        ovf_d = ovf_buf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

  // The buffer write lands before the sequencer, which passes its length state first, reads it.
  dnle_label_ram #(
    .Depth (MaxLabel),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (accept && store),
    .wr_addr_i (cnt_q[AddrW-1:0]),
    .wr_data_i (char_in_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  dnle_emit #(
    .MaxLabel (MaxLabel),
    .AddrW    (AddrW)
  ) u_emit (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req),
    .busy_o           (busy),
    .rd_en_o          (rd_en),
    .rd_addr_o        (rd_addr),
    .rd_data_i        (rd_data),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .byte_out_o       (byte_out_o),
    .is_length_o      (is_length_o),
    .run_last_o       (run_last_o),
    .name_done_o      (name_done_o),
    .label_overflow_o (label_overflow_o)
  );

  // The label count never passes the buffer depth.
  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxLabel))
    else $error("label count beyond buffer depth");

  // Starting a replay leaves a fresh, empty label behind.
  a_fresh_label: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.start |=> (cnt_q == '0) && !ovf_q)
    else $error("label state not cleared after replay start");

  // A replay request closes the input, which stays closed until the last byte of the label is loaded.
  a_stall_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.start |=> in_stall_o)
    else $error("input open during label replay");

endmodule

`default_nettype wire

[sim/dnle_wire_checker.sv]
// Checker that predicts and compares the wire-format words of the DNS name label encoder.
module dnle_wire_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [dnle_pkg::BYTE_W-1:0] char_in_i,
  input  logic                        last_char_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [dnle_pkg::BYTE_W-1:0] byte_out_i,
  input  logic                        is_length_i,
  input  logic                        run_last_i,
  input  logic                        name_done_i,
  input  logic                        label_overflow_i,
  output int unsigned                 fail_count_o,
  output int unsigned                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import dnle_pkg::*;

  localparam int unsigned IdxW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              is_len;
    logic              run_last;
    logic              name_done;
    logic              ovf;
  } wire_word_t;

  wire_word_t        words_due[$];
  logic [BYTE_W-1:0] label_chars[MAX_LABEL];
  int unsigned       label_len;
  logic              label_dropped;
  int unsigned       mismatches;

  // Buffer or drop the character, then replay the label on a separator or at the end.
  task automatic predict_wire_words(input logic [BYTE_W-1:0] c, input logic last);
    wire_word_t w;
    if (c != SEPARATOR) begin
      if (label_len < MAX_LABEL) begin
        label_chars[IdxW'(label_len)] = c;
        label_len++;
      end else begin
        label_dropped = 1'b1;
      end
    end
    if (c == SEPARATOR || last) begin
      w.data      = label_len[BYTE_W-1:0];
      w.is_len    = 1'b1;
      w.run_last  = (label_len == 0);
      w.name_done = last && (label_len == 0);
      w.ovf       = label_dropped;
      words_due.push_back(w);
      for (int i = 0; i < label_len; i++) begin
        w.data      = label_chars[IdxW'(i)];
        w.is_len    = 1'b0;
        w.run_last  = (i == label_len - 1);
        w.name_done = last && (i == label_len - 1);
        w.ovf       = 1'b0;
        words_due.push_back(w);
      end
      label_len     = 0;
      label_dropped = 1'b0;
    end
  endtask

  task automatic check_wire_word;
    wire_word_t got;
    wire_word_t want;
    got = {byte_out_i, is_length_i, run_last_i, name_done_i, label_overflow_i};
    if (words_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] unexpected word: byte %h len %b run_last %b done %b ovf %b",
                 $realtime, got.data, got.is_len, got.run_last, got.name_done, got.ovf);
    end else begin
      want = words_due.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] mismatch: expected byte %h len %b run_last %b done %b ovf %b, %s",
                   $realtime, want.data, want.is_len, want.run_last, want.name_done,
                   want.ovf, $sformatf("got byte %h len %b run_last %b done %b ovf %b",
                   got.data, got.is_len, got.run_last, got.name_done, got.ovf));
      end
    end
  endtask

  // The output is checked before the input is predicted: a word leaving at this edge
  // can never come from the character accepted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_due.delete();
      label_len     = 0;
      label_dropped = 1'b0;
      mismatches    = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_wire_word();
      if (in_valid_i && !in_stall_i) predict_wire_words(char_in_i, last_char_i);
      fail_count_o <= mismatches;
      pending_o    <= words_due.size();
    end
  end

endmodule

[sim/tb_dns_name_label_encoder_core.sv]
// Testbench top of the DNS name label encoder: stimulus, receiver stalls and the verdict.
module tb_dns_name_label_encoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  import dnle_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [BYTE_W-1:0] char_in;
  logic              last_char;
  logic              out_valid;
  logic              out_stall;
  logic [BYTE_W-1:0] byte_out;
  logic              is_length;
  logic              run_last;
  logic              name_done;
  logic              label_overflow;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned words_sent;
  int unsigned stall_left;
  bit          quiet;
  bit          mid_drain_done;

  dns_name_label_encoder_core DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .char_in_i       (char_in),
    .last_char_i     (last_char),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .byte_out_o      (byte_out),
    .is_length_o     (is_length),
    .run_last_o      (run_last),
    .name_done_o     (name_done),
    .label_overflow_o(label_overflow)
  );

  // The checker sees both channels exactly as the block does and keeps its own
  // model of the label buffer; it reports the failure count and the number of
  // words still owed by the block.
  dnle_wire_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .char_in_i       (char_in),
    .last_char_i     (last_char),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .byte_out_i      (byte_out),
    .is_length_i     (is_length),
    .run_last_i      (run_last),
    .name_done_i     (name_done),
    .label_overflow_i(label_overflow),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver side: stall comes in random bursts. Near the end of the run the
  // quiet flag turns it off so the tail runs at full rate.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 5) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offer one word and hold it until the block takes it. A random gap may come
  // first; valid is then low for the whole gap. Every drive happens on a falling
  // edge, at most once per edge.
  task automatic send_word(input logic [BYTE_W-1:0] c, input logic last);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    char_in   <= c;
    last_char <= last;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (words_sent >= 340) quiet = 1'b1;
  endtask

  // A run of ordinary characters; the final one carries the end flag if asked.
  task automatic send_label(input int unsigned len, input logic close_name);
    logic [BYTE_W-1:0] c;
    for (int i = 0; i < len; i++) begin
      do c = BYTE_W'($urandom_range(0, 255)); while (c == SEPARATOR);
      send_word(c, close_name && (i == len - 1));
    end
  endtask

  // Mostly short labels, some empty ones and now and then one near or past the limit.
  function automatic int unsigned pick_label_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(MAX_LABEL - 3, MAX_LABEL + 7);
    if (r < 3) return 0;
    return $urandom_range(1, 8);
  endfunction

  // A well-formed name: labels joined by separators, ended either on its last
  // character or on a trailing separator that carries the end flag.
  task automatic send_name();
    int unsigned labels;
    int unsigned len;
    bit          final_label;
    labels = $urandom_range(1, 4);
    for (int k = 0; k < labels; k++) begin
      len         = pick_label_len();
      final_label = (k == labels - 1);
      if (final_label && len > 0 && $urandom_range(0, 3) != 0) begin
        send_label(len, 1'b1);
      end else begin
        send_label(len, 1'b0);
        send_word(SEPARATOR, final_label);
      end
    end
  endtask

  // Hold the input idle until the block has delivered everything it owes.
  task automatic drain_outputs();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    char_in        = '0;
    last_char      = 1'b0;
    out_stall      = 1'b0;
    stall_left     = 0;
    quiet          = 1'b0;
    mid_drain_done = 1'b0;
    words_sent     = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part. A lone separator that ends the name gives one zero length word.
    send_word(SEPARATOR, 1'b1);
    // A one-character name ended on the character itself.
    send_word(8'h61, 1'b1);
    // Extreme byte values and the neighbors of the separator inside one label.
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h2D, 1'b0);
    send_word(8'h2F, 1'b0);
    send_word(SEPARATOR, 1'b0);
    // An empty label in the middle of a name.
    send_word(SEPARATOR, 1'b0);
    // Final character that is not a separator.
    send_word(8'h7F, 1'b0);
    send_word(8'h80, 1'b1);
    // Separator as the final character after a label.
    send_word(8'h78, 1'b0);
    send_word(SEPARATOR, 1'b1);
    // Single-character names back to back.
    send_word(8'hFF, 1'b1);
    send_word(8'h00, 1'b1);
    // A name of two empty labels.
    send_word(SEPARATOR, 1'b0);
    send_word(SEPARATOR, 1'b1);

    // Let the block finish everything before the long labels start.
    drain_outputs();

    // Longest label kept whole, one just over the limit, and one past the
    // limit whose dropped final character also ends the name.
    send_label(MAX_LABEL, 1'b0);
    send_word(SEPARATOR, 1'b0);
    send_label(MAX_LABEL + 1, 1'b0);
    send_word(SEPARATOR, 1'b0);
    send_label(MAX_LABEL + 2, 1'b1);

    // Random part: mostly well-formed names with random content, plus short
    // bursts of noise with stray separators and end flags anywhere.
    while (words_sent < 420) begin
      if (!mid_drain_done && words_sent >= 300) begin
        mid_drain_done = 1'b1;
        drain_outputs();
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 2) == 0)
            send_word(SEPARATOR, $urandom_range(0, 3) == 0);
          else
            send_word(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
      end else begin
        send_name();
      end
    end

    // Wind down: wait for every owed word, then keep watching the output for strays.
    drain_outputs();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, even with every label at
  // the limit and every word meeting the longest stall.
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

[filelist.f]
design/dnle_pkg.sv
design/dnle_label_ram.sv
design/dnle_emit.sv
design/dns_name_label_encoder_core.sv
sim/dnle_wire_checker.sv
sim/tb_dns_name_label_encoder_core.sv
